// ----- rtl/core/ball_project_bounce_step_unit_defines.svh -----
// Assertion macros for the ball projection and bounce step unit.
`ifndef BALL_PROJECT_BOUNCE_STEP_UNIT_DEFINES_SVH
`define BALL_PROJECT_BOUNCE_STEP_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPS_ASSERT_SAME(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPS_ASSERT_NEXT(name, pre, post, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/core/bps_pkg.sv -----
// Shared types and constants of the ball projection and bounce step unit.
`timescale 1ns / 1ps
package bps_pkg;

	localparam int SCREEN_W   = 320;
	localparam int SCREEN_H   = 200;
	localparam int COL_W      = $clog2(SCREEN_W);
	localparam int ROW_W      = $clog2(SCREEN_H);
	localparam int DEPTH_BIAS = 9000;
	localparam int CENTER_COL = 160;
	localparam int CENTER_ROW = 100;
	localparam int SHADOW_NUM = 524288;

	localparam int DIV_NW     = 24;
	localparam int DIV_DW     = 16;
	localparam int DIV_BPS    = 2;
	localparam int DIV_STAGES = DIV_NW / DIV_BPS;
	localparam int NLANE      = 3;
	localparam int LANE_COL   = 0;
	localparam int LANE_SROW  = 1;
	localparam int LANE_ROW   = 2;

	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROT_COS      = 3'd0,
		REG_ROT_SIN      = 3'd1,
		REG_GRAVITY_STEP = 3'd2,
		REG_BOUNCE_GAIN  = 3'd3,
		REG_FLOOR_LEVEL  = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic signed [15:0] rot_cos;
		logic signed [15:0] rot_sin;
		logic signed [7:0]  gravity_step;
		logic [4:0]         bounce_gain;
		logic signed [15:0] floor_level;
	} bps_cfg_t;

	typedef struct packed {
		logic signed [15:0] old_y;
		logic signed [15:0] old_v;
		logic signed [15:0] new_y;
		logic signed [15:0] new_v;
		logic               dpos;
		logic [5:0]         shade;
		logic               col_neg;
		logic               row_neg;
	} bps_side_t;

	typedef struct packed {
		logic [NLANE-1:0][DIV_NW-1:0] num;
		logic [DIV_DW-1:0]            den;
		bps_side_t                    side;
	} bps_div_req_t;

	typedef struct packed {
		logic [NLANE-1:0][DIV_NW-1:0] quo;
		bps_side_t                    side;
	} bps_div_rsp_t;

	typedef struct packed {
		logic signed [15:0] new_y;
		logic signed [15:0] new_vel;
		logic [15:0]        shadow_addr;
		logic               shadow_on;
		logic [15:0]        ball_addr;
		logic               ball_on;
		logic [7:0]         shade_index;
	} bps_result_t;

endpackage

// ----- rtl/core/bps_front.sv -----
// Front pipeline: rotation products, gravity, bounce, depth and divider operands.
`timescale 1ns / 1ps
module bps_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bps_pkg::bps_cfg_t     cfg,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic signed [15:0]    pos_x,
	input  logic signed [15:0]    pos_y,
	input  logic signed [15:0]    pos_z,
	input  logic signed [15:0]    vel_y,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bps_pkg::bps_div_req_t req
);
	import bps_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4;
	logic r1, r2, r3, r4;

	logic signed [31:0] p_zc_s1, p_xs_s1, p_zs_s1, p_xc_s1;
	logic signed [15:0] y_s1, v0_s1, ny_s1, nv_s1;

	logic signed [17:0] depth_s2;
	logic signed [24:0] t_s2;
	logic signed [22:0] bprod_s2;
	logic               bnc_s2;
	logic signed [15:0] y_s2, v0_s2, ny_s2, nv_s2;

	logic signed [17:0] depth_s3;
	logic signed [25:0] nc_s3;
	logic signed [15:0] y_s3, v0_s3, ny_s3, nv_s3;

	bps_div_req_t req_s4;

	logic signed [15:0] g16, nv_c, ny_c;
	logic signed [32:0] ddiff, tsum, dq, tq;
	logic signed [24:0] t8;
	logic signed [22:0] bq;
	logic signed [15:0] bv;
	logic signed [25:0] nc_mag;
	logic signed [22:0] rn, rn_mag;
	logic               dpos;

	assign r4 = !v_s4 || out_ready;
	assign r3 = !v_s3 || r4;
	assign r2 = !v_s2 || r3;
	assign r1 = !v_s1 || r2;
	assign in_ready  = r1;
	assign out_valid = v_s4;
	assign req       = req_s4;

	always_comb begin
		g16   = 16'(cfg.gravity_step);
		nv_c  = vel_y + g16;
		ny_c  = pos_y + nv_c;
		ddiff = 33'(p_zc_s1) - 33'(p_xs_s1);
		tsum  = 33'(p_zs_s1) + 33'(p_xc_s1);
		dq    = (ddiff + (ddiff < 0 ? 33'sd65535 : 33'sd0)) >>> 16;
		tq    = (tsum + (tsum < 0 ? 33'sd255 : 33'sd0)) >>> 8;
		t8    = (t_s2 + (t_s2 < 0 ? 25'sd7 : 25'sd0)) >>> 3;
		bq    = (bprod_s2 + (bprod_s2 < 0 ? 23'sd15 : 23'sd0)) >>> 4;
		bv    = 16'(bq);
		nc_mag = nc_s3 < 0 ? -nc_s3 : nc_s3;
		rn     = 23'(ny_s3) <<< 6;
		rn_mag = rn < 0 ? -rn : rn;
		dpos   = depth_s3 > 0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (r1) v_s1 <= in_valid;
			if (r2) v_s2 <= v_s1;
			if (r3) v_s3 <= v_s2;
			if (r4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && r1) begin
			p_zc_s1 <= pos_z * cfg.rot_cos;
			p_xs_s1 <= pos_x * cfg.rot_sin;
			p_zs_s1 <= pos_z * cfg.rot_sin;
			p_xc_s1 <= pos_x * cfg.rot_cos;
			y_s1    <= pos_y;
			v0_s1   <= vel_y;
			ny_s1   <= ny_c;
			nv_s1   <= nv_c;
		end
		if (v_s1 && r2) begin
			depth_s2 <= 18'(dq) + 18'(DEPTH_BIAS);
			t_s2     <= 25'(tq);
			bprod_s2 <= -(23'(nv_s1) * 23'($signed({1'b0, cfg.bounce_gain})));
			bnc_s2   <= ny_s1 >= cfg.floor_level;
			y_s2     <= y_s1;
			v0_s2    <= v0_s1;
			ny_s2    <= ny_s1;
			nv_s2    <= nv_s1;
		end
		if (v_s2 && r3) begin
			depth_s3 <= depth_s2;
			nc_s3    <= 26'(t_s2) + 26'(t8);
			y_s3     <= y_s2;
			v0_s3    <= v0_s2;
			if (bnc_s2) begin
				ny_s3 <= ny_s2 + bv;
				nv_s3 <= bv;
			end else begin
				ny_s3 <= ny_s2;
				nv_s3 <= nv_s2;
			end
		end
		if (v_s3 && r4) begin
			req_s4.num[LANE_COL]  <= DIV_NW'(nc_mag);
			req_s4.num[LANE_SROW] <= DIV_NW'(SHADOW_NUM);
			req_s4.num[LANE_ROW]  <= DIV_NW'(rn_mag);
			req_s4.den            <= dpos ? DIV_DW'(depth_s3) : DIV_DW'(1);
			req_s4.side.old_y     <= y_s3;
			req_s4.side.old_v     <= v0_s3;
			req_s4.side.new_y     <= ny_s3;
			req_s4.side.new_v     <= nv_s3;
			req_s4.side.dpos      <= dpos;
			req_s4.side.shade     <= depth_s3[13:8];
			req_s4.side.col_neg   <= nc_s3 < 0;
			req_s4.side.row_neg   <= rn < 0;
		end
	end

endmodule

// ----- rtl/core/bps_div.sv -----
// Pipelined three-lane restoring divider sharing one divisor, two quotient bits per stage.
`timescale 1ns / 1ps
module bps_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bps_pkg::bps_div_req_t req,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bps_pkg::bps_div_rsp_t rsp
);
	import bps_pkg::*;

	typedef struct packed {
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] rem;
		logic [DIV_NW-1:0] quo;
	} lane_t;

	function automatic lane_t div_step(lane_t a, logic [DIV_DW-1:0] den);
		lane_t           r;
		logic [DIV_DW:0] trial;
		r = a;
		for (int i = 0; i < DIV_BPS; i++) begin
			trial = {r.rem, r.num[DIV_NW-1]};
			r.num = {r.num[DIV_NW-2:0], 1'b0};
			if (trial >= {1'b0, den}) begin
				r.rem = DIV_DW'(trial - {1'b0, den});
				r.quo = {r.quo[DIV_NW-2:0], 1'b1};
			end else begin
				r.rem = trial[DIV_DW-1:0];
				r.quo = {r.quo[DIV_NW-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	lane_t             lane_s [DIV_STAGES][NLANE];
	logic [DIV_DW-1:0] den_s  [DIV_STAGES];
	bps_side_t         side_s [DIV_STAGES];
	logic              v_s    [DIV_STAGES];
	logic              rdy    [DIV_STAGES+1];
	lane_t             nxt    [DIV_STAGES][NLANE];

	always_comb begin
		rdy[DIV_STAGES] = out_ready;
		for (int k = DIV_STAGES - 1; k >= 0; k--) begin
			rdy[k] = !v_s[k] || rdy[k+1];
		end
	end

	always_comb begin
		for (int l = 0; l < NLANE; l++) begin
			nxt[0][l] = div_step(lane_t'{num: req.num[l], rem: '0, quo: '0}, req.den);
			for (int k = 1; k < DIV_STAGES; k++) begin
				nxt[k][l] = div_step(lane_s[k-1][l], den_s[k-1]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < DIV_STAGES; k++) v_s[k] <= 1'b0;
		end else begin
			if (rdy[0]) v_s[0] <= in_valid;
			for (int k = 1; k < DIV_STAGES; k++) begin
				if (rdy[k]) v_s[k] <= v_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && rdy[0]) begin
			lane_s[0] <= nxt[0];
			den_s[0]  <= req.den;
			side_s[0] <= req.side;
		end
		for (int k = 1; k < DIV_STAGES; k++) begin
			if (v_s[k-1] && rdy[k]) begin
				lane_s[k] <= nxt[k];
				den_s[k]  <= den_s[k-1];
				side_s[k] <= side_s[k-1];
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[DIV_STAGES-1];

	always_comb begin
		for (int l = 0; l < NLANE; l++) rsp.quo[l] = lane_s[DIV_STAGES-1][l].quo;
		rsp.side = side_s[DIV_STAGES-1];
	end

endmodule

// ----- rtl/core/bps_back.sv -----
// Back pipeline: signed quotients, screen tests, pixel addresses and output register.
`timescale 1ns / 1ps
module bps_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  bps_pkg::bps_div_rsp_t rsp,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bps_pkg::bps_result_t  res
);
	import bps_pkg::*;

	logic            v_s17, v_s18, r17, r18;
	logic [COL_W-1:0] col_s17;
	logic [ROW_W-1:0] srow_s17, row_s17;
	logic            son_s17, bon_s17;
	bps_side_t       side_s17;
	bps_result_t     res_s18;

	logic signed [25:0] cq, col_full, rq, row_full;
	logic [24:0]        srow_full;
	logic               col_ok, srow_ok, row_ok;

	assign r18 = !v_s18 || out_ready;
	assign r17 = !v_s17 || r18;
	assign in_ready  = r17;
	assign out_valid = v_s18;
	assign res       = res_s18;

	always_comb begin
		cq = $signed(26'(rsp.quo[LANE_COL]));
		if (rsp.side.col_neg) cq = -cq;
		rq = $signed(26'(rsp.quo[LANE_ROW]));
		if (rsp.side.row_neg) rq = -rq;
		col_full  = cq + 26'(CENTER_COL);
		row_full  = rq + 26'(CENTER_ROW);
		srow_full = 25'(rsp.quo[LANE_SROW]) + 25'(CENTER_ROW);
		col_ok    = col_full >= 0 && col_full < 26'(SCREEN_W);
		row_ok    = row_full >= 0 && row_full < 26'(SCREEN_H);
		srow_ok   = srow_full < 25'(SCREEN_H);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s17 <= 1'b0;
			v_s18 <= 1'b0;
		end else begin
			if (r17) v_s17 <= in_valid;
			if (r18) v_s18 <= v_s17;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && r17) begin
			col_s17  <= col_full[COL_W-1:0];
			srow_s17 <= srow_full[ROW_W-1:0];
			row_s17  <= row_full[ROW_W-1:0];
			son_s17  <= rsp.side.dpos && col_ok && srow_ok;
			bon_s17  <= rsp.side.dpos && col_ok && srow_ok && row_ok;
			side_s17 <= rsp.side;
		end
		if (v_s17 && r18) begin
			res_s18.shadow_on   <= son_s17;
			res_s18.ball_on     <= bon_s17;
			res_s18.new_y       <= son_s17 ? side_s17.new_y : side_s17.old_y;
			res_s18.new_vel     <= son_s17 ? side_s17.new_v : side_s17.old_v;
			res_s18.shadow_addr <= son_s17 ?
				16'(32'(srow_s17) * 32'(SCREEN_W) + 32'(col_s17)) : 16'd0;
			res_s18.ball_addr   <= bon_s17 ?
				16'(32'(row_s17) * 32'(SCREEN_W) + 32'(col_s17)) : 16'd0;
			res_s18.shade_index <= bon_s17 ? {side_s17.shade, 2'b00} : 8'd0;
		end
	end

endmodule

// ----- rtl/core/ball_project_bounce_step_unit.sv -----
// Top level of the ball projection and bounce step unit.
//
//   channel  direction  words
//   s_*      in         ball: pos_x, pos_y, pos_z, vel_y
//   m_*      out        result: height, velocity, addresses, flags, shade
//   cfg_*    in         register write: index, data
//
// One word is accepted per cycle unless a stall reaches the input; the divider sets
// the depth: 4 front, 12 divider (two quotient bits each) and 2 back stages.
// Reset clears all valid bits and loads the register reset values.
// Each stage advances when it is empty or its successor advances, so bubbles close
// up and input keeps flowing while a finished word waits at the output, until all
// 18 stages hold words.
`timescale 1ns / 1ps
`include "ball_project_bounce_step_unit_defines.svh"
module ball_project_bounce_step_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // pos_x, pos_y, pos_z, vel_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata,   // new_y, new_vel, shadow_addr, shadow_on, ball_addr,
	                               // ball_on, shade_index, zero fill
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [bps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0] cfg_data
);
	import bps_pkg::*;

	bps_cfg_t     cfg_q;
	bps_div_req_t req;
	bps_div_rsp_t rsp;
	bps_result_t  res;
	logic         f_valid, f_ready, d_valid, d_ready;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rot_cos      <= 16'sd0;
			cfg_q.rot_sin      <= 16'sd0;
			cfg_q.gravity_step <= 8'sd0;
			cfg_q.bounce_gain  <= 5'd16;
			cfg_q.floor_level  <= 16'sd8000;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_ROT_COS:      cfg_q.rot_cos      <= cfg_data;
				REG_ROT_SIN:      cfg_q.rot_sin      <= cfg_data;
				REG_GRAVITY_STEP: cfg_q.gravity_step <= cfg_data[7:0];
				REG_BOUNCE_GAIN:  cfg_q.bounce_gain  <= cfg_data[4:0];
				REG_FLOOR_LEVEL:  cfg_q.floor_level  <= cfg_data;
				default: ;
			endcase
		end
	end

	bps_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.pos_x     (s_tdata[15:0]),
		.pos_y     (s_tdata[31:16]),
		.pos_z     (s_tdata[47:32]),
		.vel_y     (s_tdata[63:48]),
		.out_valid (f_valid),
		.out_ready (f_ready),
		.req       (req)
	);

	bps_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (f_valid),
		.in_ready  (f_ready),
		.req       (req),
		.out_valid (d_valid),
		.out_ready (d_ready),
		.rsp       (rsp)
	);

	bps_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (d_valid),
		.in_ready  (d_ready),
		.rsp       (rsp),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.res       (res)
	);

	assign m_tdata = {6'd0, res.shade_index, res.ball_on, res.ball_addr, res.shadow_on,
		res.shadow_addr, res.new_vel, res.new_y};

	`BPS_ASSERT_SAME(a_ball_needs_shadow, m_tvalid && res.ball_on, res.shadow_on,
		"ball visible while shadow hidden")
	`BPS_ASSERT_SAME(a_hidden_shadow_zero, m_tvalid && !res.shadow_on,
		res.shadow_addr == 16'd0, "hidden shadow has a nonzero address")
	`BPS_ASSERT_SAME(a_hidden_ball_zero, m_tvalid && !res.ball_on,
		res.ball_addr == 16'd0 && res.shade_index == 8'd0,
		"hidden ball has a nonzero address or shade")
	`BPS_ASSERT_NEXT(a_stall_holds_word, m_tvalid && !m_tready, $stable(m_tdata),
		"output word changed under stall")

endmodule

// ----- test/ball_project_bounce_step_unit_tb.sv -----
// Self-checking testbench of the ball projection and bounce step unit.
`timescale 1ns / 1ps
module ball_project_bounce_step_unit_tb;
	import bps_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        m_tvalid;
	logic        m_tready;
	logic [79:0] m_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [15:0] cfg_data;

	ball_project_bounce_step_unit dut (.*);

	typedef struct packed {
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] pos_z;
		logic signed [15:0] vel_y;
	} ball_t;

	typedef struct {
		ball_t ball;
		bit    has_exp;
		logic [79:0] exp_word;
	} dir_row_t;

	logic signed [15:0] cur_cos, cur_sin, cur_floor;
	logic signed [7:0]  cur_grav;
	logic [4:0]         cur_gain;

	logic [79:0] expected_words[$];
	int  mismatches;
	int  gap_hold;
	bit  hold_out;

	function automatic logic [79:0] pack_result(bps_result_t r);
		return {6'd0, r.shade_index, r.ball_on, r.ball_addr, r.shadow_on,
			r.shadow_addr, r.new_vel, r.new_y};
	endfunction

	function automatic logic [79:0] project_ball(ball_t b);
		longint x, y, z, v, depth, t, col, srow, row, ny, nv;
		bps_result_t r;
		x = b.pos_x; y = b.pos_y; z = b.pos_z; v = b.vel_y;
		r = '0;
		ny = y; nv = v;
		depth = (z * longint'(cur_cos) - x * longint'(cur_sin)) / 65536 + DEPTH_BIAS;
		if (depth > 0) begin
			t = (z * longint'(cur_sin) + x * longint'(cur_cos)) / 256;
			col = (t + t / 8) / depth + CENTER_COL;
			srow = SHADOW_NUM / depth + CENTER_ROW;
			if (col >= 0 && col < SCREEN_W && srow >= 0 && srow < SCREEN_H) begin
				r.shadow_on = 1'b1;
				r.shadow_addr = 16'(srow * SCREEN_W + col);
				nv = longint'($signed(16'(v + longint'(cur_grav))));
				ny = longint'($signed(16'(y + nv)));
				if (ny >= longint'(cur_floor)) begin
					nv = longint'($signed(16'((-nv * longint'(cur_gain)) / 16)));
					ny = longint'($signed(16'(ny + nv)));
				end
				row = (ny * 64) / depth + CENTER_ROW;
				if (row >= 0 && row < SCREEN_H) begin
					r.ball_on = 1'b1;
					r.ball_addr = 16'(row * SCREEN_W + col);
					r.shade_index = 8'(depth >> 6) & 8'hFC;
				end
			end
		end
		r.new_y = 16'(ny);
		r.new_vel = 16'(nv);
		return pack_result(r);
	endfunction

	always #6 clk = ~clk;

	initial begin
		#50ms;
		$display("ball_project_bounce_step_unit_tb NOT OK");
		$finish;
	end

	task automatic write_reg(cfg_reg_t idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_ROT_COS:      cur_cos = val;
			REG_ROT_SIN:      cur_sin = val;
			REG_GRAVITY_STEP: cur_grav = val[7:0];
			REG_BOUNCE_GAIN:  cur_gain = val[4:0];
			REG_FLOOR_LEVEL:  cur_floor = val;
			default: ;
		endcase
	endtask

	task automatic set_motion(logic [15:0] c, logic [15:0] s, logic [15:0] g,
			logic [15:0] gn, logic [15:0] f);
		write_reg(REG_ROT_COS, c);
		write_reg(REG_ROT_SIN, s);
		write_reg(REG_GRAVITY_STEP, g);
		write_reg(REG_BOUNCE_GAIN, gn);
		write_reg(REG_FLOOR_LEVEL, f);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_ball(ball_t b, bit has_exp, logic [79:0] exp_word);
		int gap;
		gap = (gap_hold > 0) ? 0 : $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {b.vel_y, b.pos_z, b.pos_y, b.pos_x};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_words.push_back(has_exp ? exp_word : project_ball(b));
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (expected_words.size() != 0) @(posedge clk);
		repeat (25) @(posedge clk);
	endtask

	function automatic ball_t random_ball(int kind);
		ball_t b;
		b = {$urandom, $urandom};
		if (kind != 0) begin
			b.pos_x = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
			b.pos_z = $signed(16'($urandom_range(0, 16000))) - 16'sd8000;
			b.pos_y = $signed(16'($urandom_range(0, 20000))) - 16'sd10000;
			b.vel_y = $signed(16'($urandom_range(0, 1200))) - 16'sd600;
		end
		return b;
	endfunction

	// Output side: random stalls plus one long hold-off.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_out) begin
				m_tready <= 1'b0;
				repeat (60) @(posedge clk);
				hold_out = 1'b0;
			end
			stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!(m_tvalid && m_tready)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		logic [79:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected word %h", m_tdata);
			end else begin
				want = expected_words.pop_front();
				if (want !== m_tdata) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %h got %h", want, m_tdata);
				end
			end
		end
	end

	initial begin
		dir_row_t rows[$];
		dir_row_t r;
		bps_result_t hidden;
		int wait_cycles;
		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_ROT_COS;
		cfg_data = '0;
		mismatches = 0;
		gap_hold = 0;
		hold_out = 1'b0;
		cur_cos = 0; cur_sin = 0; cur_grav = 0; cur_gain = 16; cur_floor = 8000;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// With reset registers the ball sits straight ahead: depth 9000, column 160,
		// shadow row 158, ball row 100 + y*64/9000.
		hidden = '0;
		hidden.new_y = 16'sd0; hidden.new_vel = 16'sd0;
		hidden.shadow_on = 1'b1; hidden.shadow_addr = 16'(158 * 320 + 160);
		hidden.ball_on = 1'b1; hidden.ball_addr = 16'(100 * 320 + 160);
		hidden.shade_index = 8'(9000 >> 6) & 8'hFC;
		r.ball = '0; r.has_exp = 1; r.exp_word = pack_result(hidden);
		rows.push_back(r);
		foreach (rows[i]) send_ball(rows[i].ball, rows[i].has_exp, rows[i].exp_word);
		rows.delete();
		wait_drained();

		// Extremes, bounces, and negative depth via a rotated view.
		set_motion(16'sd16384, 16'sd0, 16'sd127, 16'd31, 16'sh8000);
		r.has_exp = 0; r.exp_word = '0;
		r.ball = {16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000}; rows.push_back(r);
		r.ball = {16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF}; rows.push_back(r);
		r.ball = {16'sd0, 16'sd100, 16'sd0, 16'sd50}; rows.push_back(r);
		r.ball = {16'sd300, 16'sd0, 16'sd2000, 16'sd0}; rows.push_back(r);
		r.ball = {-16'sd300, 16'sd0, -16'sd2000, 16'sd0}; rows.push_back(r);
		foreach (rows[i]) send_ball(rows[i].ball, 0, '0);
		wait_drained();
		set_motion(-16'sd16384, 16'sd16384, -16'sd128, 16'd0, 16'sd32767);
		foreach (rows[i]) send_ball(rows[i].ball, 0, '0);
		r.ball = {16'sd0, 16'sd0, 16'sh7FFF, 16'sd0}; send_ball(r.ball, 0, '0);
		r.ball = {16'sh7FFF, 16'sd0, 16'sd0, 16'sd0}; send_ball(r.ball, 0, '0);
		wait_drained();

		for (int phase = 0; phase < 7; phase++) begin
			set_motion(16'($urandom_range(0, 32768) - 16384),
				16'($urandom_range(0, 32768) - 16384),
				16'($urandom_range(0, 40) - 20), 16'($urandom_range(0, 31)),
				16'($urandom_range(0, 16000) - 4000));
			for (int i = 0; i < 100; i++) begin
				if (phase == 2 && i == 10) begin
					hold_out = 1'b1;
					gap_hold = 40;
				end
				if (gap_hold > 0) gap_hold--;
				if (phase == 4 && i == 50) wait_drained();
				send_ball(random_ball($urandom_range(0, 4)), 0, '0);
			end
			wait_drained();
		end

		wait_cycles = 0;
		while (expected_words.size() != 0 && wait_cycles < 5000) begin
			@(posedge clk);
			wait_cycles++;
		end
		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0)
			$display("ball_project_bounce_step_unit_tb OK");
		else
			$display("ball_project_bounce_step_unit_tb NOT OK");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+rtl/core
rtl/core/bps_pkg.sv
rtl/core/bps_front.sv
rtl/core/bps_div.sv
rtl/core/bps_back.sv
rtl/core/ball_project_bounce_step_unit.sv
test/ball_project_bounce_step_unit_tb.sv
